// ===== design/mm2_pkg.sv =====
// ----------------------------------------------------------------------------
// mm2_pkg
// Shared constants and types for the streaming MurmurHash2 engine.
// ----------------------------------------------------------------------------
package mm2_pkg;

    localparam logic [31:0] MIX_MUL      = 32'h5bd1e995;
    localparam int unsigned MIX_SHIFT    = 24;
    localparam int unsigned FIN_SHIFT_A  = 13;
    localparam int unsigned FIN_SHIFT_B  = 15;
    localparam logic [31:0] SEED_RESET   = 32'd97;
    localparam int unsigned QUEUE_DEPTH  = 4;

    // register map: index of each register in the APB space (one word each)
    localparam logic        REG_SEED     = 1'b0;

    // what the back end does with one queued word
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,   // last word with no valid bytes: no data, finalize only
        OP_FULL = 2'd1,   // full mixed word
        OP_TAIL = 2'd2    // 1 to 3 tail bytes, already masked
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        first;
        logic        last;
        logic [31:0] data;    // mixed word, or masked tail bytes
        logic [31:0] start;   // seed xor length, used on the first word
    } q_entry_t;

    typedef struct packed {
        logic fin;            // back end is finalizing a message
    } back_stat_t;

endpackage

// ===== design/mm2_front.sv =====
// ----------------------------------------------------------------------------
// mm2_front
// Accepts words, classifies them and mixes full words in a two-stage
// multiply pipeline before handing them to the queue.
// ----------------------------------------------------------------------------
module mm2_front import mm2_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_valid_bytes,
    input  logic        s_is_last,
    input  logic [30:0] s_message_length,
    input  logic [31:0] seed,
    output logic        push_valid,
    input  logic        push_ready,
    output q_entry_t    push_entry
);

    logic        in_msg_reg;
    logic        s1_valid_reg;
    q_entry_t    s1_reg;
    logic        s2_valid_reg;
    q_entry_t    s2_reg;

    logic        accept;
    logic        s2_adv;
    logic        is_full;
    logic [31:0] tail_mask;
    logic [31:0] k_first;
    logic [31:0] k_shift;
    logic [31:0] k_second;
    q_entry_t    s1_next;
    q_entry_t    s2_next;

    assign s2_adv     = !s2_valid_reg || push_ready;
    assign s_ready    = !s1_valid_reg || s2_adv;
    assign accept     = s_valid && s_ready;
    assign push_valid = s2_valid_reg;
    assign push_entry = s2_reg;

    // a short count counts only on the last word
    assign is_full = !s_is_last || s_valid_bytes[2];

    always_comb begin
        case (s_valid_bytes[1:0])
            2'd1:    tail_mask = 32'h0000_00ff;
            2'd2:    tail_mask = 32'h0000_ffff;
            2'd3:    tail_mask = 32'h00ff_ffff;
            default: tail_mask = 32'h0000_0000;
        endcase
    end

    assign k_first = s_data_word * MIX_MUL;

    always_comb begin
        s1_next.first = !in_msg_reg;
        s1_next.last  = s_is_last;
        s1_next.start = seed ^ {1'b0, s_message_length};
        if (is_full) begin
            s1_next.op   = OP_FULL;
            s1_next.data = k_first;
        end else if (s_valid_bytes[1:0] != 2'd0) begin
            s1_next.op   = OP_TAIL;
            s1_next.data = s_data_word & tail_mask;
        end else begin
            s1_next.op   = OP_NONE;
            s1_next.data = 32'd0;
        end
    end

    assign k_shift  = s1_reg.data ^ (s1_reg.data >> MIX_SHIFT);
    assign k_second = k_shift * MIX_MUL;

    always_comb begin
        s2_next = s1_reg;
        if (s1_reg.op == OP_FULL) begin
            s2_next.data = k_second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_msg_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                in_msg_reg   <= !s_is_last;
                s1_valid_reg <= 1'b1;
            end else if (s2_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s2_adv) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= s1_next;
        end
        if (s2_adv && s1_valid_reg) begin
            s2_reg <= s2_next;
        end
    end

endmodule

// ===== design/mm2_queue.sv =====
// ----------------------------------------------------------------------------
// mm2_queue
// Small circular queue of classified words between front and back end.
// ----------------------------------------------------------------------------
module mm2_queue import mm2_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push_valid,
    output logic     push_ready,
    input  q_entry_t push_entry,
    output logic     pop_valid,
    input  logic     pop,
    output q_entry_t pop_entry,
    output logic [$clog2(DEPTH+1)-1:0] fill
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH+1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    q_entry_t        slots_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_entry  = slots_reg[rd_ptr_reg];
    assign fill       = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== design/mm2_back.sv =====
// ----------------------------------------------------------------------------
// mm2_back
// Folds queued words into the running hash, finalizes on the last word and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module mm2_back import mm2_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_pop,
    input  q_entry_t    q_entry,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash_value,
    output back_stat_t  stat
);

    typedef enum logic [1:0] {
        ST_MIX = 2'b01,
        ST_FIN = 2'b10
    } back_state_t;

    back_state_t state_reg, state_next;
    logic [31:0] hash_reg, hash_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_hash_reg, out_hash_next;

    logic [31:0] h_in;
    logic [31:0] h_mix;
    logic [31:0] fin_pre;
    logic [31:0] fin_prod;
    logic        out_free;

    assign h_in     = q_entry.first ? q_entry.start : hash_reg;
    assign fin_pre  = hash_reg ^ (hash_reg >> FIN_SHIFT_A);
    assign fin_prod = fin_pre * MIX_MUL;
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        case (q_entry.op)
            OP_FULL: h_mix = (h_in * MIX_MUL) ^ q_entry.data;
            OP_TAIL: h_mix = (h_in ^ q_entry.data) * MIX_MUL;
            default: h_mix = h_in;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_hash_next  = out_hash_reg;
        q_pop          = 1'b0;
        case (state_reg)
            ST_MIX: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    hash_next = h_mix;
                    if (q_entry.last) begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                // wait for the output register before finishing
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_hash_next  = fin_prod ^ (fin_prod >> FIN_SHIFT_B);
                    state_next     = ST_MIX;
                end
            end
            default: begin
                state_next = ST_MIX;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_MIX;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hash_reg     <= hash_next;
        out_hash_reg <= out_hash_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_hash_value = out_hash_reg;
    assign stat.fin     = (state_reg == ST_FIN);

endmodule

// ===== design/murmur2_hash_stream_top.sv =====
// ----------------------------------------------------------------------------
// murmur2_hash_stream_top
// Streaming 32-bit MurmurHash2 over little-endian message words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one 32-bit word per transfer with its valid byte
//   count and an end-of-message flag; the first word of a message carries
//   the declared byte length, which seeds the hash as seed xor length.
//   Result channel (m_*): one hash word per message, after its last word.
//   APB port: register 0 (byte address 0) holds the seed, reset value 97.
// Throughput: the front end takes one word a cycle unless the queue stalls
//   it, through its two-stage word multiply pipeline; the back end folds one
//   word a cycle outside finalize, the single hash multiply in its loop
//   setting that pace. The last word adds a finalize multiply step, which
//   waits while the output register is held. The last word passes s1_reg,
//   s2_reg, a queue slot, hash_reg and out_hash_reg to m_hash_value.
// Reset: clears the pipeline, the queue and the output; the seed returns
//   to 97 and the next word starts a new message.
// Stall: a held result stops the back end, the queue fills, then s_ready
//   drops; nothing is lost.
// ----------------------------------------------------------------------------
module murmur2_hash_stream_top import mm2_pkg::*; #(
    parameter int unsigned Q_DEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_valid_bytes,
    input  logic        s_is_last,
    input  logic [30:0] s_message_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] seed_reg;
    logic        push_valid;
    logic        push_ready;
    q_entry_t    push_entry;
    logic        q_valid;
    logic        q_pop;
    q_entry_t    q_entry;
    logic [$clog2(Q_DEPTH+1)-1:0] q_fill;
    back_stat_t  back_stat;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SEED) ? seed_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= SEED_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_SEED)) begin
            seed_reg <= pwdata;
        end
    end

    mm2_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_word      (s_data_word),
        .s_valid_bytes    (s_valid_bytes),
        .s_is_last        (s_is_last),
        .s_message_length (s_message_length),
        .seed             (seed_reg),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_entry       (push_entry)
    );

    mm2_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_entry  (q_entry),
        .fill       (q_fill)
    );

    mm2_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_entry      (q_entry),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value),
        .stat         (back_stat)
    );

`ifndef SYNTHESIS
    // a fresh result only comes out of the finalize step
    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(back_stat.fin))
        else $error("result raised without finalize");

    // queue fill never exceeds its depth
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_fill <= ($clog2(Q_DEPTH+1))'(Q_DEPTH))
        else $error("queue overfilled");

    // finalize lasts while the output register is still held
    a_fin_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        back_stat.fin && m_valid && !m_ready |=> back_stat.fin)
        else $error("finalize left while output stalled");

    // back end never pops while finalizing
    a_no_pop_in_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        back_stat.fin |-> !q_pop)
        else $error("queue popped during finalize");
`endif

endmodule
